// File: sv/prp_pkg.sv
`default_nettype none
package prp_pkg;

  localparam int FIELD_W       = 11;
  localparam int MODE_W        = 2;
  localparam int COLOR_W       = 16;
  localparam int RANK_W        = 16;
  localparam int POSITIONS_DEF = 1024;

  localparam logic [FIELD_W-1:0] IN_USE_RESET = 11'd1024;

  localparam logic [MODE_W-1:0] MODE_PAINT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAINT,
    ST_DRAIN,
    ST_QREAD,
    ST_QWAIT
  } state_t;

  // per-cycle commands from the sequencer to the datapath
  typedef struct packed {
    logic rd_en;
    logic clr_wr;
    logic paint_chk;
    logic out_load;
    logic hit_ok;
  } ctl_t;

endpackage
`default_nettype wire

// File: sv/priority_range_paint_unit.sv
`default_nettype none
// channel  | signals                                         | dir
// ---------+-------------------------------------------------+-----
// cfg      | cfg_valid, cfg_ready, cfg_data                  | in
// in       | in_valid, in_stall, mode, span_start, span_end, | in
//          | paint_color, paint_rank                         |
// out      | out_valid, out_stall, color, covered            | out
//
// paint: one read-compare-write per position of the clipped interval
//   through the single line memory, read and write overlapped
// query: one memory read plus any wait for the output register to drain
// clear: one memory word zeroed per cycle, across all POSITIONS words
// after reset a clearing pass over all POSITIONS words runs before in_stall drops
// in_stall is high whenever an item is in progress; out_stall only holds a
//   query until its result register is free
module priority_range_paint_unit #(
  parameter int POSITIONS = prp_pkg::POSITIONS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [prp_pkg::FIELD_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [prp_pkg::MODE_W-1:0]   mode,
  input  logic [prp_pkg::FIELD_W-1:0]  span_start,
  input  logic [prp_pkg::FIELD_W-1:0]  span_end,
  input  logic [prp_pkg::COLOR_W-1:0]  paint_color,
  input  logic [prp_pkg::RANK_W-1:0]   paint_rank,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [prp_pkg::COLOR_W-1:0]  color,
  output logic                         covered
);
  import prp_pkg::*;

  localparam int AW = $clog2(POSITIONS);
  localparam int DW = RANK_W + COLOR_W;

  logic [FIELD_W-1:0] in_use;
  logic [COLOR_W-1:0] pc;
  logic [RANK_W-1:0]  pr;
  logic               in_fire, busy, out_busy;
  ctl_t               ctl;
  logic [AW-1:0]      addr, pend_addr, wr_addr;
  logic               wr_en;
  logic [DW-1:0]      wr_data, rd_data;
  logic [RANK_W-1:0]  rd_rank;
  logic [COLOR_W-1:0] rd_color;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_fire   = in_valid && !in_stall;
  assign out_busy  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= IN_USE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pc <= paint_color;
      pr <= paint_rank;
    end
  end

  prp_ctrl #(
    .POSITIONS (POSITIONS),
    .AW        (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .mode       (mode),
    .span_start (span_start),
    .span_end   (span_end),
    .in_use     (in_use),
    .out_busy   (out_busy),
    .busy       (busy),
    .ctl        (ctl),
    .addr       (addr),
    .pend_addr  (pend_addr)
  );

  assign rd_rank  = rd_data[DW-1:COLOR_W];
  assign rd_color = rd_data[COLOR_W-1:0];

  // the rank compare decides whether the read-back word is overwritten
  always_comb begin
    wr_en   = ctl.clr_wr || (ctl.paint_chk && (rd_rank < pr));
    wr_addr = ctl.clr_wr ? addr : pend_addr;
    wr_data = ctl.clr_wr ? '0 : {pr, pc};
  end

  prp_ram #(
    .WIDTH (DW),
    .DEPTH (POSITIONS),
    .AW    (AW)
  ) u_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctl.rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      covered <= ctl.hit_ok && (rd_rank != '0);
      color   <= (ctl.hit_ok && (rd_rank != '0)) ? rd_color : '0;
    end
  end

endmodule
`default_nettype wire

// File: sv/prp_ram.sv
`default_nettype none
module prp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: sv/prp_ctrl.sv
`default_nettype none
module prp_ctrl #(
  parameter int POSITIONS = prp_pkg::POSITIONS_DEF,
  parameter int AW        = $clog2(POSITIONS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_fire,
  input  logic [prp_pkg::MODE_W-1:0]  mode,
  input  logic [prp_pkg::FIELD_W-1:0] span_start,
  input  logic [prp_pkg::FIELD_W-1:0] span_end,
  input  logic [prp_pkg::FIELD_W-1:0] in_use,
  input  logic                        out_busy,
  output logic                        busy,
  output prp_pkg::ctl_t               ctl,
  output logic [AW-1:0]               addr,
  output logic [AW-1:0]               pend_addr
);
  import prp_pkg::*;

  // wide enough for both the field range and the line length
  localparam int CW = (AW + 1 > FIELD_W) ? AW + 1 : FIELD_W;

  state_t        state, state_next;
  logic [AW-1:0] cur, cur_next;
  logic [AW-1:0] last, last_next;
  logic          hit_ok, hit_ok_next;
  logic          pend;

  logic [CW-1:0] lim, s_clip, e_clip, q_pos;
  logic          q_ok;

  always_comb begin
    lim    = (CW'(in_use) > CW'(POSITIONS)) ? CW'(POSITIONS) : CW'(in_use);
    s_clip = (span_start == '0) ? CW'(1) : CW'(span_start);
    e_clip = (CW'(span_end) > lim) ? lim : CW'(span_end);
    q_pos  = CW'(span_start);
    q_ok   = (span_start != '0) && (q_pos <= lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      cur    <= '0;
      pend   <= 1'b0;
      hit_ok <= 1'b0;
    end else begin
      state  <= state_next;
      cur    <= cur_next;
      pend   <= (state == ST_PAINT);
      hit_ok <= hit_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    last      <= last_next;
    pend_addr <= cur;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (cur == AW'(POSITIONS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          priority if (mode == MODE_PAINT) begin
            if (s_clip <= e_clip) state_next = ST_PAINT;
          end else if (mode == MODE_QUERY) begin
            state_next = ST_QREAD;
          end else begin
            if (mode == MODE_CLEAR) state_next = ST_CLEAR;
          end
        end
      end
      ST_PAINT: begin
        if (cur == last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_IDLE;
      ST_QREAD: state_next = ST_QWAIT;
      ST_QWAIT: begin
        if (!out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_next    = cur;
    last_next   = last;
    hit_ok_next = hit_ok;
    unique case (state)
      ST_CLEAR, ST_PAINT: cur_next = cur + AW'(1);
      ST_IDLE: begin
        if (in_fire) begin
          priority if (mode == MODE_PAINT) begin
            cur_next  = AW'(s_clip - CW'(1));
            last_next = AW'(e_clip - CW'(1));
          end else if (mode == MODE_QUERY) begin
            cur_next    = q_ok ? AW'(q_pos - CW'(1)) : '0;
            hit_ok_next = q_ok;
          end else begin
            cur_next = '0;
          end
        end
      end
      default: cur_next = cur;
    endcase
  end

  always_comb begin
    busy          = (state != ST_IDLE);
    addr          = cur;
    ctl.rd_en     = (state == ST_PAINT) || (state == ST_QREAD);
    ctl.clr_wr    = (state == ST_CLEAR);
    ctl.paint_chk = pend;
    ctl.out_load  = (state == ST_QWAIT) && !out_busy;
    ctl.hit_ok    = hit_ok;
  end

endmodule
`default_nettype wire

// File: tb/sv/priority_range_paint_unit_tb.sv
`timescale 1ns / 100ps
module priority_range_paint_unit_tb;
  import prp_pkg::*;

  localparam int LINE_POS = POSITIONS_DEF;
  localparam int SETTLE = 1100;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  op;
    logic [FIELD_W-1:0] first;
    logic [FIELD_W-1:0] last;
    logic [COLOR_W-1:0] hue;
    logic [RANK_W-1:0]  prio;
  } line_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] hue;
    logic               hit;
  } probe_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [FIELD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MODE_W-1:0] mode = '0;
  logic [FIELD_W-1:0] span_start = '0;
  logic [FIELD_W-1:0] span_end = '0;
  logic [COLOR_W-1:0] paint_color = '0;
  logic [RANK_W-1:0] paint_rank = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COLOR_W-1:0] color;
  logic covered;

  // predicted line contents and active length
  logic [COLOR_W-1:0] hue_mem [LINE_POS];
  logic [RANK_W-1:0] prio_mem [LINE_POS];
  logic [FIELD_W-1:0] line_len = IN_USE_RESET;

  line_item_t item_backlog[$];
  probe_result_t expected_probes[$];

  int queued_count = 0;
  int accepted_count = 0;
  int paint_count = 0;
  int probe_count = 0;
  int wipe_count = 0;
  int probes_checked = 0;
  int settings_done = 0;
  int errors = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  int jam_left = 0;
  bit jam_done = 0;
  bit calm = 0;

  priority_range_paint_unit #(.POSITIONS(LINE_POS)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .span_start(span_start),
    .span_end(span_end),
    .paint_color(paint_color),
    .paint_rank(paint_rank),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .color(color),
    .covered(covered)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic wipe_line();
    for (int p = 0; p < LINE_POS; p++) begin
      hue_mem[p] = '0;
      prio_mem[p] = '0;
    end
  endtask

  task automatic predict_line_item(input line_item_t it);
    int lim;
    int lo;
    int hi;
    probe_result_t res;
    lim = (line_len > LINE_POS) ? LINE_POS : int'(line_len);
    case (it.op)
      MODE_PAINT: begin
        paint_count++;
        lo = (it.first < 1) ? 1 : int'(it.first);
        hi = (int'(it.last) > lim) ? lim : int'(it.last);
        for (int p = lo; p <= hi; p++) begin
          if (it.prio > prio_mem[p-1]) begin
            prio_mem[p-1] = it.prio;
            hue_mem[p-1] = it.hue;
          end
        end
      end
      MODE_QUERY: begin
        probe_count++;
        res = '0;
        if (it.first >= 1 && int'(it.first) <= lim && prio_mem[it.first-1] != 0) begin
          res.hue = hue_mem[it.first-1];
          res.hit = 1'b1;
        end
        expected_probes = {expected_probes, res};
      end
      MODE_CLEAR: begin
        wipe_count++;
        wipe_line();
      end
      default: ;
    endcase
  endtask

  task automatic add_item(input logic [MODE_W-1:0] op, input int first, input int last,
                          input int hue, input int prio);
    line_item_t it;
    it.op = op;
    it.first = FIELD_W'(first);
    it.last = FIELD_W'(last);
    it.hue = COLOR_W'(hue);
    it.prio = RANK_W'(prio);
    item_backlog = {item_backlog, it};
    queued_count++;
  endtask

  function automatic int pick_pos(input int eff, input int lo_w, input int hi_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(lo_w, hi_w);
    if (r < 85) return $urandom_range(1, LINE_POS);
    if (r < 90) return 1;
    if (r < 95) return LINE_POS;
    return (eff < LINE_POS) ? eff + 1 : LINE_POS - 1;
  endfunction

  task automatic add_random(input int count, input int len_setting);
    int eff;
    int lo_w;
    int hi_w;
    int r;
    int s;
    int e;
    eff = (len_setting == 0) ? 1 : ((len_setting > LINE_POS) ? LINE_POS : len_setting);
    for (int i = 0; i < count; i++) begin
      // drift the busy window now and then so paints and queries overlap
      if (i % 20 == 0) begin
        lo_w = $urandom_range(1, eff);
        hi_w = (lo_w + 40 > LINE_POS) ? LINE_POS : lo_w + 40;
      end
      r = $urandom_range(0, 99);
      s = pick_pos(eff, lo_w, hi_w);
      if (r < 3) begin
        add_item(MODE_CLEAR, s, $urandom_range(1, LINE_POS), $urandom_range(0, 65535),
                 $urandom_range(0, 65535));
      end else if (r < 50) begin
        if ($urandom_range(0, 19) == 0) begin
          s = 1;
          e = LINE_POS;
        end else if ($urandom_range(0, 49) == 0 && s > 1) begin
          e = $urandom_range(1, s - 1);
        end else begin
          e = s + $urandom_range(0, 24);
          if (e > LINE_POS) e = LINE_POS;
        end
        add_item(MODE_PAINT, s, e, $urandom_range(1, 65535), $urandom_range(1, 65535));
      end else begin
        add_item(MODE_QUERY, s, $urandom_range(1, LINE_POS), $urandom_range(0, 65535),
                 $urandom_range(0, 65535));
      end
    end
  endtask

  // quiet means every beat taken, every query answered and the last walk done
  task automatic wait_quiet();
    while (accepted_count != queued_count || expected_probes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_line_len(input int v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= FIELD_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    line_len = FIELD_W'(v);
    settings_done++;
  endtask

  // driver: holds a beat until taken, then moves on or idles for a burst
  always @(posedge clk) begin : driver
    line_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        nxt.op = mode;
        nxt.first = span_start;
        nxt.last = span_end;
        nxt.hue = paint_color;
        nxt.prio = paint_rank;
        predict_line_item(nxt);
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (item_backlog.size() != 0) begin
          nxt = item_backlog.pop_front();
          mode <= nxt.op;
          span_start <= nxt.first;
          span_end <= nxt.last;
          paint_color <= nxt.hue;
          paint_rank <= nxt.prio;
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: short random stalls, plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (jam_left > 0) begin
      jam_left--;
      out_stall <= 1'b1;
    end else if (!jam_done && probes_checked >= 60) begin
      jam_done = 1;
      jam_left = 400;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : monitor
    probe_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_probes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got color %h covered %b",
                 $time, color, covered);
      end else begin
        want = expected_probes.pop_front();
        probes_checked++;
        if (color !== want.hue) begin
          errors++;
          $display("%0t: color mismatch, expected %h, got %h", $time, want.hue, color);
        end
        if (covered !== want.hit) begin
          errors++;
          $display("%0t: covered mismatch, expected %b, got %b", $time, want.hit, covered);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_probes.size());
      $display("priority_range_paint_unit_tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int len_plan [5];
    len_plan = '{300, 1, 2047, 513, 1024};
    wipe_line();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    set_line_len(1024);
    add_item(MODE_QUERY, 1, 0, 0, 0);
    add_item(MODE_PAINT, 1, 1024, 16'hFFFF, 1);
    add_item(MODE_QUERY, 1024, 0, 0, 0);
    add_item(MODE_PAINT, 5, 9, 16'h1234, 16'hFFFF);
    add_item(MODE_PAINT, 3, 12, 16'h5555, 100);
    add_item(MODE_QUERY, 7, 0, 0, 0);
    add_item(MODE_QUERY, 3, 0, 0, 0);
    // equal rank must not override
    add_item(MODE_PAINT, 20, 25, 16'hAAAA, 200);
    add_item(MODE_PAINT, 20, 25, 16'hBBBB, 200);
    add_item(MODE_QUERY, 22, 0, 0, 0);
    add_item(MODE_PAINT, 30, 40, 16'h7777, 0);
    add_item(MODE_QUERY, 35, 0, 0, 0);
    // start of zero counts as one, color zero still covers
    add_item(MODE_PAINT, 0, 2, 16'h0000, 300);
    add_item(MODE_QUERY, 1, 0, 0, 0);
    add_item(MODE_QUERY, 0, 0, 0, 0);
    add_item(MODE_PAINT, 50, 45, 16'h0101, 400);
    add_item(MODE_QUERY, 47, 0, 0, 0);
    add_item(MODE_IGNORED, 60, 70, 16'h0202, 500);
    add_item(MODE_QUERY, 60, 0, 0, 0);
    add_item(MODE_PAINT, 1023, 1024, 16'h03FF, 16'h7FFF);
    add_item(MODE_QUERY, 1023, 0, 0, 0);
    wait_quiet();

    set_line_len(8);
    add_item(MODE_QUERY, 10, 0, 0, 0);
    add_item(MODE_PAINT, 1, 1024, 16'h0808, 1000);
    wait_quiet();

    set_line_len(0);
    add_item(MODE_QUERY, 1, 0, 0, 0);
    add_item(MODE_PAINT, 1, 3, 16'h0C0C, 2000);
    wait_quiet();

    // contents beyond the shortened line come back unchanged
    set_line_len(1024);
    add_item(MODE_QUERY, 10, 0, 0, 0);
    add_item(MODE_QUERY, 1, 0, 0, 0);
    add_item(MODE_CLEAR, 0, 0, 0, 0);
    add_item(MODE_QUERY, 5, 0, 0, 0);

    foreach (len_plan[k]) begin
      wait_quiet();
      set_line_len(len_plan[k]);
      if (k == 4) calm = 1;
      add_random(110, len_plan[k]);
    end
    wait_quiet();

    $display("%0d beats taken: %0d paints, %0d queries, %0d clears; %0d line lengths",
             accepted_count, paint_count, probe_count, wipe_count, settings_done);
    $display("%0d query results checked, %0d mismatches", probes_checked, errors);
    if (errors == 0)
      $display("priority_range_paint_unit_tb: clean");
    else
      $display("priority_range_paint_unit_tb: errors");
    $finish;
  end

endmodule

// File: filelist.f
sv/prp_pkg.sv
sv/prp_ram.sv
sv/prp_ctrl.sv
sv/priority_range_paint_unit.sv
tb/sv/priority_range_paint_unit_tb.sv
